@@ hdl/bspline_de_boor_eval_unit_defines.svh @@
// assertion macros for the b-spline evaluator
// used by the top level only; needs nothing else
`ifndef BSPLINE_DE_BOOR_EVAL_UNIT_DEFINES_SVH
`define BSPLINE_DE_BOOR_EVAL_UNIT_DEFINES_SVH

// same-cycle implication, quiet during reset
`define BDB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define BDB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/bdb_pkg.sv @@
// shared constants, codes and controller/datapath link types
// no dependencies
`default_nettype none

package bdb_pkg;

   // sizes
   localparam int MAX_KNOTS  = 64;
   localparam int MAX_ORDER  = 6;
   localparam int DATA_W     = 32;
   localparam int TIDX_W     = $clog2(MAX_KNOTS);
   localparam int ORD_W      = $clog2(MAX_ORDER);
   localparam int DEG_W      = 3;
   localparam int CNT_W      = 7;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // arithmetic widths
   localparam int ALPHA_FRAC = 30;
   localparam int Q_W        = ALPHA_FRAC + 1;
   localparam int DIV_STEPS  = Q_W;
   localparam int MAG_W      = DATA_W + 1;
   localparam int REM_W      = DATA_W + 2;
   localparam int AM_W       = DATA_W;
   localparam int SPLIT      = 16;
   localparam int PLO_W      = SPLIT + AM_W;
   localparam int ACC_W      = MAG_W + AM_W;
   localparam int SUM_W      = DATA_W + 5;
   localparam int STEP_W     = $clog2(DIV_STEPS);

   typedef logic [1:0] req_kind_type;
   typedef logic [1:0] status_type;
   typedef logic [3:0] dp_op_type;

   // item kinds
   localparam req_kind_type REQ_KNOT = 2'd0;
   localparam req_kind_type REQ_COEF = 2'd1;
   localparam req_kind_type REQ_EVAL = 2'd2;

   // result status
   localparam status_type ST_OK        = 2'd0;
   localparam status_type ST_DISABLED  = 2'd1;
   localparam status_type ST_BAD_CFG   = 2'd2;
   localparam status_type ST_ZERO_SPAN = 2'd3;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DEGREE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT  = 2'd2;

   // datapath operations
   localparam dp_op_type OP_NONE   = 4'd0;
   localparam dp_op_type OP_LAT_LO = 4'd1;
   localparam dp_op_type OP_CLAMP  = 4'd2;
   localparam dp_op_type OP_LAT_TA = 4'd3;
   localparam dp_op_type OP_LAT_TB = 4'd4;
   localparam dp_op_type OP_DIFF   = 4'd5;
   localparam dp_op_type OP_MAGS   = 4'd6;
   localparam dp_op_type OP_DIV    = 4'd7;
   localparam dp_op_type OP_MULA   = 4'd8;
   localparam dp_op_type OP_MULB   = 4'd9;
   localparam dp_op_type OP_SUM    = 4'd10;
   localparam dp_op_type OP_FIN    = 4'd11;

   // controller to datapath
   typedef struct packed {
      logic              capture;
      status_type        start_status;
      logic              knot_we;
      logic              coef_we;
      logic [TIDX_W-1:0] knot_raddr;
      logic [TIDX_W-1:0] coef_raddr;
      logic [ORD_W-1:0]  d_raddr;
      logic              d_we;
      logic [ORD_W-1:0]  d_waddr;
      logic              d_blend;
      dp_op_type         op;
      logic              emit;
   } bdb_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic knot_lt_x;
      logic out_free;
   } bdb_stat_type;

endpackage

`default_nettype wire

@@ hdl/bdb_if.sv @@
// request, response and configuration channel interfaces
// depends on bdb_pkg
`default_nettype none

interface bdb_req_if import bdb_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [1:0]               req_type;
   logic [TIDX_W-1:0]        table_index;
   logic signed [DATA_W-1:0] table_value;
   logic signed [DATA_W-1:0] eval_point;
   modport source (output valid, req_type, table_index, table_value, eval_point,
                   input ready);
   modport sink (input valid, req_type, table_index, table_value, eval_point,
                 output ready);
endinterface

interface bdb_rsp_if import bdb_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [DATA_W-1:0] spline_value;
   logic [1:0]               status;
   modport source (output valid, spline_value, status, input ready);
   modport sink (input valid, spline_value, status, output ready);
endinterface

interface bdb_csr_if import bdb_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hdl/bdb_ram.sv @@
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module bdb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

`default_nettype wire

@@ hdl/bdb_datapath.sv @@
// datapath: knot, coefficient and blend stores, clamp, divider, multiplier,
// output register; depends on bdb_pkg and bdb_ram
`default_nettype none

module bdb_datapath import bdb_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire bdb_cmd_type              cmd,
   output      bdb_stat_type             stat,
   input  wire logic [TIDX_W-1:0]        table_index,
   input  wire logic signed [DATA_W-1:0] table_value,
   input  wire logic signed [DATA_W-1:0] eval_point,
   output      logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   output      logic signed [DATA_W-1:0] rsp_value,
   output      logic [1:0]               rsp_status
);

   logic [DATA_W-1:0] knot_rdata;
   logic [DATA_W-1:0] coef_rdata;
   logic [DATA_W-1:0] d_rdata;
   logic [DATA_W-1:0] d_wdata;

   logic signed [DATA_W-1:0] x_ff, lo_ff, ta_ff, tb_ff, dj_ff, dj1_ff, res_ff;
   logic signed [MAG_W-1:0]  num_ff, den_ff, diff_ff;
   logic [MAG_W-1:0]         den_mag_ff, diff_mag_ff;
   logic [REM_W-1:0]         rem_ff;
   logic [Q_W-1:0]           quo_ff;
   logic                     big_ff, zero_ff, alpha_neg_ff, diff_neg_ff;
   logic [AM_W-1:0]          am_ff;
   logic [PLO_W-1:0]         plo_ff;
   logic [ACC_W-1:0]         acc_ff;
   status_type               status_ff;
   logic                     out_valid_ff;
   logic signed [DATA_W-1:0] out_value_ff;
   status_type               out_status_ff;

   logic signed [DATA_W-1:0] knot_s;
   logic signed [DATA_W-1:0] clamp_x;
   logic [MAG_W-1:0]         num_mag, den_mag, diff_mag;
   logic [REM_W-1:0]         rem_sub;
   logic                     rem_ge;
   logic [AM_W-1:0]          am_w;
   logic [ACC_W-1:0]         rnd;
   logic signed [SUM_W-1:0]  blend_sum;
   logic signed [DATA_W-1:0] blend_sat;

   // tables
   bdb_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KNOTS)) u_knot_ram (
      .clock (clock),
      .we    (cmd.knot_we),
      .waddr (table_index),
      .wdata (table_value),
      .raddr (cmd.knot_raddr),
      .rdata (knot_rdata)
   );

   bdb_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KNOTS)) u_coef_ram (
      .clock (clock),
      .we    (cmd.coef_we),
      .waddr (table_index),
      .wdata (table_value),
      .raddr (cmd.coef_raddr),
      .rdata (coef_rdata)
   );

   // blend column d[0..degree]
   bdb_ram #(.WIDTH(DATA_W), .DEPTH(MAX_ORDER)) u_d_ram (
      .clock (clock),
      .we    (cmd.d_we),
      .waddr (cmd.d_waddr),
      .wdata (d_wdata),
      .raddr (cmd.d_raddr),
      .rdata (d_rdata)
   );

   // clamp and search compare
   always_comb begin
      knot_s = $signed(knot_rdata);
      if (x_ff < lo_ff) begin
         clamp_x = lo_ff;
      end else if (x_ff > knot_s) begin
         clamp_x = knot_s;
      end else begin
         clamp_x = x_ff;
      end
   end

   // magnitudes and one restoring division step
   always_comb begin
      num_mag  = num_ff[MAG_W-1] ? MAG_W'(-num_ff) : MAG_W'(num_ff);
      den_mag  = den_ff[MAG_W-1] ? MAG_W'(-den_ff) : MAG_W'(den_ff);
      diff_mag = diff_ff[MAG_W-1] ? MAG_W'(-diff_ff) : MAG_W'(diff_ff);
      rem_ge   = rem_ff >= {1'b0, den_mag_ff};
      rem_sub  = rem_ge ? rem_ff - {1'b0, den_mag_ff} : rem_ff;
   end

   // alpha magnitude: zero span gives 0, ratio at or above two clamps to 2.0
   always_comb begin
      if (zero_ff) begin
         am_w = '0;
      end else if (big_ff) begin
         am_w = AM_W'(1) << (ALPHA_FRAC + 1);
      end else begin
         am_w = AM_W'(quo_ff);
      end
   end

   // round, blend and saturate
   always_comb begin
      rnd = acc_ff + (ACC_W'(1) << (ALPHA_FRAC - 1));
      if (diff_neg_ff ^ alpha_neg_ff) begin
         blend_sum = SUM_W'(dj1_ff) - $signed(SUM_W'(rnd[ACC_W-1:ALPHA_FRAC]));
      end else begin
         blend_sum = SUM_W'(dj1_ff) + $signed(SUM_W'(rnd[ACC_W-1:ALPHA_FRAC]));
      end
      if (blend_sum > $signed(SUM_W'({1'b0, {(DATA_W-1){1'b1}}}))) begin
         blend_sat = {1'b0, {(DATA_W-1){1'b1}}};
      end else if (blend_sum < -$signed(SUM_W'({1'b1, {(DATA_W-1){1'b0}}}))) begin
         blend_sat = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
         blend_sat = blend_sum[DATA_W-1:0];
      end
      d_wdata = cmd.d_blend ? blend_sat : coef_rdata;
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         x_ff   <= eval_point;
         res_ff <= '0;
      end
      case (cmd.op)
         OP_LAT_LO: lo_ff <= knot_s;
         OP_CLAMP:  x_ff <= clamp_x;
         OP_LAT_TA: begin
            ta_ff <= knot_s;
            dj_ff <= $signed(d_rdata);
         end
         OP_LAT_TB: begin
            tb_ff  <= knot_s;
            dj1_ff <= $signed(d_rdata);
         end
         OP_DIFF: begin
            num_ff  <= MAG_W'(x_ff) - MAG_W'(ta_ff);
            den_ff  <= MAG_W'(tb_ff) - MAG_W'(ta_ff);
            diff_ff <= MAG_W'(dj_ff) - MAG_W'(dj1_ff);
         end
         OP_MAGS: begin
            den_mag_ff   <= den_mag;
            diff_mag_ff  <= diff_mag;
            rem_ff       <= {1'b0, num_mag};
            quo_ff       <= '0;
            big_ff       <= {1'b0, num_mag} >= {den_mag, 1'b0};
            zero_ff      <= den_ff == '0;
            alpha_neg_ff <= num_ff[MAG_W-1] ^ den_ff[MAG_W-1];
            diff_neg_ff  <= diff_ff[MAG_W-1];
         end
         OP_DIV: begin
            rem_ff <= {rem_sub[REM_W-2:0], 1'b0};
            quo_ff <= {quo_ff[Q_W-2:0], rem_ge};
         end
         OP_MULA: begin
            am_ff  <= am_w;
            plo_ff <= PLO_W'(diff_mag_ff[SPLIT-1:0]) * PLO_W'(am_w);
         end
         OP_MULB: begin
            acc_ff <= ACC_W'(plo_ff)
                    + ((ACC_W'(diff_mag_ff[MAG_W-1:SPLIT]) * ACC_W'(am_ff)) << SPLIT);
         end
         OP_FIN: res_ff <= $signed(d_rdata);
         default: begin
         end
      endcase
   end

   // item status, zero span is sticky through the evaluation
   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= ST_OK;
      end else if (cmd.capture) begin
         status_ff <= cmd.start_status;
      end else if (cmd.op == OP_MAGS && den_ff == '0) begin
         status_ff <= ST_ZERO_SPAN;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         out_value_ff  <= res_ff;
         out_status_ff <= status_ff;
      end
   end

   assign stat.knot_lt_x = knot_s < x_ff;
   assign stat.out_free  = !out_valid_ff || rsp_ready;
   assign rsp_valid      = out_valid_ff;
   assign rsp_value      = out_value_ff;
   assign rsp_status     = out_status_ff;

endmodule

`default_nettype wire

@@ hdl/bdb_controller.sv @@
// controller: sequences clamp, interval search, load and blend passes
// depends on bdb_pkg
`default_nettype none

module bdb_controller import bdb_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_ready,
   input  wire req_kind_type     req_kind,
   input  wire logic             cfg_enable,
   input  wire logic [DEG_W-1:0] cfg_degree,
   input  wire logic [CNT_W-1:0] cfg_count,
   input  wire bdb_stat_type     stat,
   output      bdb_cmd_type      cmd
);

   localparam logic [4:0] S_IDLE  = 5'd0;
   localparam logic [4:0] S_LO    = 5'd1;
   localparam logic [4:0] S_HI    = 5'd2;
   localparam logic [4:0] S_CLAMP = 5'd3;
   localparam logic [4:0] S_SRD   = 5'd4;
   localparam logic [4:0] S_SCMP  = 5'd5;
   localparam logic [4:0] S_LRD   = 5'd6;
   localparam logic [4:0] S_LWR   = 5'd7;
   localparam logic [4:0] S_TA    = 5'd8;
   localparam logic [4:0] S_TB    = 5'd9;
   localparam logic [4:0] S_LAT   = 5'd10;
   localparam logic [4:0] S_DIFF  = 5'd11;
   localparam logic [4:0] S_MAGS  = 5'd12;
   localparam logic [4:0] S_DIV   = 5'd13;
   localparam logic [4:0] S_MULA  = 5'd14;
   localparam logic [4:0] S_MULB  = 5'd15;
   localparam logic [4:0] S_SUM   = 5'd16;
   localparam logic [4:0] S_FRD   = 5'd17;
   localparam logic [4:0] S_FLAT  = 5'd18;
   localparam logic [4:0] S_EMIT  = 5'd19;

   logic [4:0]        state_ff, state_in;
   logic [TIDX_W-1:0] i_ff, i_in;
   logic [ORD_W-1:0]  j_ff, j_in;
   logic [ORD_W-1:0]  r_ff, r_in;
   logic [STEP_W-1:0] step_ff, step_in;

   logic [CNT_W-1:0] k_w, i_w, j_w, r_w;
   logic [CNT_W-1:0] search_end;
   logic             cfg_bad;
   logic             accept;
   status_type       start_status;

   // widened loop indexes for address arithmetic
   always_comb begin
      k_w        = CNT_W'(cfg_degree);
      i_w        = CNT_W'(i_ff);
      j_w        = CNT_W'(j_ff);
      r_w        = CNT_W'(r_ff);
      search_end = cfg_count - k_w - CNT_W'(2);
      cfg_bad    = cfg_degree == '0 || CNT_W'(cfg_degree) >= CNT_W'(MAX_ORDER)
                   || cfg_count < (k_w << 1) + CNT_W'(2)
                   || cfg_count > CNT_W'(MAX_KNOTS);
      accept     = req_valid && req_ready;
      if (req_kind != REQ_EVAL) begin
         start_status = ST_OK;
      end else if (!cfg_enable) begin
         start_status = ST_DISABLED;
      end else if (cfg_bad) begin
         start_status = ST_BAD_CFG;
      end else begin
         start_status = ST_OK;
      end
   end

   // next state and commands
   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      r_in     = r_ff;
      step_in  = step_ff;
      cmd      = '0;
      cmd.op   = OP_NONE;
      cmd.start_status = start_status;
      req_ready = state_ff == S_IDLE;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               cmd.knot_we = req_kind == REQ_KNOT;
               cmd.coef_we = req_kind == REQ_COEF;
               if (req_kind == REQ_EVAL && cfg_enable && !cfg_bad) begin
                  state_in = S_LO;
               end else begin
                  state_in = S_EMIT;
               end
            end
         end
         S_LO: begin
            cmd.knot_raddr = TIDX_W'(k_w);
            state_in = S_HI;
         end
         S_HI: begin
            cmd.knot_raddr = TIDX_W'(cfg_count - k_w - CNT_W'(1));
            cmd.op = OP_LAT_LO;
            state_in = S_CLAMP;
         end
         S_CLAMP: begin
            cmd.op = OP_CLAMP;
            i_in = TIDX_W'(k_w);
            state_in = S_SRD;
         end
         S_SRD: begin
            cmd.knot_raddr = TIDX_W'(i_w + CNT_W'(1));
            if (i_w < search_end) begin
               state_in = S_SCMP;
            end else begin
               j_in = '0;
               state_in = S_LRD;
            end
         end
         S_SCMP: begin
            if (stat.knot_lt_x) begin
               i_in = i_ff + TIDX_W'(1);
               state_in = S_SRD;
            end else begin
               j_in = '0;
               state_in = S_LRD;
            end
         end
         S_LRD: begin
            cmd.coef_raddr = TIDX_W'(j_w + i_w - k_w);
            state_in = S_LWR;
         end
         S_LWR: begin
            cmd.d_we = 1'b1;
            cmd.d_waddr = j_ff;
            if (j_w == k_w) begin
               r_in = ORD_W'(1);
               j_in = ORD_W'(cfg_degree);
               state_in = S_TA;
            end else begin
               j_in = j_ff + ORD_W'(1);
               state_in = S_LRD;
            end
         end
         S_TA: begin
            cmd.knot_raddr = TIDX_W'(j_w + i_w - k_w);
            cmd.d_raddr = j_ff;
            state_in = S_TB;
         end
         S_TB: begin
            cmd.knot_raddr = TIDX_W'(j_w + CNT_W'(1) + i_w - r_w);
            cmd.d_raddr = j_ff - ORD_W'(1);
            cmd.op = OP_LAT_TA;
            state_in = S_LAT;
         end
         S_LAT: begin
            cmd.op = OP_LAT_TB;
            state_in = S_DIFF;
         end
         S_DIFF: begin
            cmd.op = OP_DIFF;
            state_in = S_MAGS;
         end
         S_MAGS: begin
            cmd.op = OP_MAGS;
            step_in = '0;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.op = OP_DIV;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               state_in = S_MULA;
            end
         end
         S_MULA: begin
            cmd.op = OP_MULA;
            state_in = S_MULB;
         end
         S_MULB: begin
            cmd.op = OP_MULB;
            state_in = S_SUM;
         end
         S_SUM: begin
            cmd.op = OP_SUM;
            cmd.d_we = 1'b1;
            cmd.d_waddr = j_ff;
            cmd.d_blend = 1'b1;
            // last j of this pass
            if (j_ff == r_ff) begin
               if (r_w == k_w) begin
                  state_in = S_FRD;
               end else begin
                  r_in = r_ff + ORD_W'(1);
                  j_in = ORD_W'(cfg_degree);
                  state_in = S_TA;
               end
            end else begin
               j_in = j_ff - ORD_W'(1);
               state_in = S_TA;
            end
         end
         S_FRD: begin
            cmd.d_raddr = ORD_W'(cfg_degree);
            state_in = S_FLAT;
         end
         S_FLAT: begin
            cmd.op = OP_FIN;
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and loop counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         r_ff     <= '0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         r_ff     <= r_in;
         step_ff  <= step_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/bspline_de_boor_eval_unit.sv @@
// B-spline evaluator using the triangular blend recursion, Q16.16 fixed point.
// Channels: req_bus (sink) takes one item at a time: write knot, write
// coefficient or evaluate at eval_point. rsp_bus (source) gives exactly one
// item per request: spline_value and status. csr_bus writes the enable,
// degree and knot count registers; it is always ready.
// A write or a rejected evaluation goes from the S_EMIT state into the output
// register, and the next item is taken once S_EMIT is left.
// An evaluation steps through clamp, interval search, coefficient load and
// k blend passes, k the degree; each blend step runs the restoring divider
// for alpha and then the split multiplier. One item is in work at a time.
// The result sits in an output register; the next request is taken while it
// waits. A stalled receiver holds the block only once a second result is
// ready to go out.
// Reset: registers return to enable 0, degree 3, knot count 8; the tables
// hold no defined contents until written.
// depends on bdb_pkg, bdb_if, bdb_ram, bdb_datapath, bdb_controller
`default_nettype none

`include "bspline_de_boor_eval_unit_defines.svh"

module bspline_de_boor_eval_unit import bdb_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   bdb_req_if.sink   req_bus,
   bdb_rsp_if.source rsp_bus,
   bdb_csr_if.sink   csr_bus
);

   logic             enable_ff;
   logic [DEG_W-1:0] degree_ff;
   logic [CNT_W-1:0] count_ff;
   bdb_cmd_type      cmd;
   bdb_stat_type     stat;
   logic             req_ready;

   // configuration registers
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b0;
         degree_ff <= DEG_W'(3);
         count_ff  <= CNT_W'(8);
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_ENABLE: enable_ff <= csr_bus.data[0];
            CSR_DEGREE: degree_ff <= csr_bus.data[DEG_W-1:0];
            CSR_COUNT:  count_ff  <= csr_bus.data[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer
   bdb_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_ready  (req_ready),
      .req_kind   (req_bus.req_type),
      .cfg_enable (enable_ff),
      .cfg_degree (degree_ff),
      .cfg_count  (count_ff),
      .stat       (stat),
      .cmd        (cmd)
   );

   assign req_bus.ready = req_ready;

   // arithmetic and storage
   bdb_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .table_index (req_bus.table_index),
      .table_value (req_bus.table_value),
      .eval_point  (req_bus.eval_point),
      .rsp_valid   (rsp_bus.valid),
      .rsp_ready   (rsp_bus.ready),
      .rsp_value   (rsp_bus.spline_value),
      .rsp_status  (rsp_bus.status)
   );

   // one item in work at a time
   `BDB_ASSERT_NXT(a_one_in_work, clock, reset, req_bus.valid && req_ready, !req_ready, "item accepted while busy")
   // disabled or bad configuration returns zero
   `BDB_ASSERT_IMP(a_reject_zero, clock, reset, rsp_bus.valid && (rsp_bus.status == ST_DISABLED || rsp_bus.status == ST_BAD_CFG), rsp_bus.spline_value == '0, "rejected item with nonzero value")
   // a write never reaches the blend passes
   `BDB_ASSERT_NXT(a_write_short, clock, reset, req_bus.valid && req_ready && req_bus.req_type != REQ_EVAL, cmd.op == OP_NONE, "write item started the datapath")

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// testbench for the b-spline evaluator: loads knot and coefficient
// tables, evaluates under many register settings and checks each response
// depends on bdb_pkg, bdb_if and bspline_de_boor_eval_unit
`default_nettype none

module tb;
   import bdb_pkg::*;

   localparam int CYCLE_LIMIT = 3000000;
   localparam int HOLD_CYCLES = 3000;

   // unused item kind, answered like a write
   localparam req_kind_type REQ_SPARE = 2'd3;

   typedef struct {
      logic [1:0]               kind;
      logic [TIDX_W-1:0]        idx;
      logic signed [DATA_W-1:0] tval;
      logic signed [DATA_W-1:0] xval;
   } spline_req_type;

   typedef struct {
      logic signed [DATA_W-1:0] value;
      status_type               status;
   } spline_rsp_type;

   logic clock;
   logic reset;

   bdb_req_if req_bus ();
   bdb_rsp_if rsp_bus ();
   bdb_csr_if csr_bus ();

   bspline_de_boor_eval_unit i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // queues between stimulus, driver and checker
   spline_req_type pend_q[$];
   spline_rsp_type expect_q[$];

   // predictor state
   longint knot_mem[MAX_KNOTS];
   longint coef_mem[MAX_KNOTS];
   logic   cfg_enable;
   int     cfg_degree;
   int     cfg_count;

   int     errors;
   int     cycles;
   int     n_items;
   int     n_evals;
   int     n_status[4];
   int     n_checked;
   bit     steady;
   int     hold_asked;
   int     hold_served;
   int     issued;
   int     taken;

   // knot plan of the current phase, mirrors what was queued
   longint plan_knot[MAX_KNOTS];

   always #10 clock = ~clock;

   // ---------------------------------------------------------------
   // predictor
   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(0) - v : v;
   endfunction

   function automatic longint clip(longint v, int w);
      longint hi, lo;
      hi = (longint'(1) <<< (w - 1)) - 1;
      lo = -hi - 1;
      return (v > hi) ? hi : ((v < lo) ? lo : v);
   endfunction

   function automatic longint alpha_ratio(longint num, longint den);
      longint unsigned a;
      a = (magnitude(num) << 30) / magnitude(den);
      if (a > (64'd1 << 31))
         a = 64'd1 << 31;
      return ((num < 0) != (den < 0)) ? -longint'(a) : longint'(a);
   endfunction

   function automatic longint blend_product(longint diff, longint alpha);
      longint unsigned dm, am, r;
      dm = magnitude(diff);
      am = magnitude(alpha);
      r  = (dm >> 30) * am + ((((dm & ((64'd1 << 30) - 1)) * am) + (64'd1 << 29)) >> 30);
      return ((diff < 0) != (alpha < 0)) ? -longint'(r) : longint'(r);
   endfunction

   function automatic spline_rsp_type evaluate_item(spline_req_type it);
      spline_rsp_type rs;
      longint x, lo, hi, ta, den, alpha;
      longint d[MAX_ORDER];
      int k, n, i;
      rs.value  = '0;
      rs.status = ST_OK;
      if (it.kind == REQ_KNOT) begin
         knot_mem[it.idx] = longint'(it.tval);
      end else if (it.kind == REQ_COEF) begin
         coef_mem[it.idx] = longint'(it.tval);
      end else if (it.kind == REQ_EVAL) begin
         k = cfg_degree;
         n = cfg_count;
         if (!cfg_enable) begin
            rs.status = ST_DISABLED;
         end else if (k < 1 || k >= MAX_ORDER || n < 2 * k + 2 || n > MAX_KNOTS) begin
            rs.status = ST_BAD_CFG;
         end else begin
            x  = longint'(it.xval);
            lo = knot_mem[k];
            hi = knot_mem[n - k - 1];
            x  = (x < lo) ? lo : ((x > hi) ? hi : x);
            i  = k;
            while (i < n - k - 2 && knot_mem[i + 1] < x)
               i++;
            for (int j = 0; j <= k; j++)
               d[j] = coef_mem[j + i - k];
            for (int r = 1; r <= k; r++) begin
               for (int j = k; j >= r; j--) begin
                  ta    = knot_mem[j + i - k];
                  den   = knot_mem[j + 1 + i - r] - ta;
                  alpha = 0;
                  if (den == 0)
                     rs.status = ST_ZERO_SPAN;
                  else
                     alpha = alpha_ratio(x - ta, den);
                  d[j] = clip(d[j - 1] + blend_product(d[j] - d[j - 1], alpha), DATA_W);
               end
            end
            rs.value = DATA_W'(clip(d[k], 32));
         end
      end
      return rs;
   endfunction

   // ---------------------------------------------------------------
   // gap length: mostly none, some short, a few long
   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (steady || p < 65)
         return 0;
      else if (p < 94)
         return $urandom_range(1, 4);
      else
         return $urandom_range(20, 90);
   endfunction

   // request driver, changes at the falling edge
   int send_gap;
   always @(negedge clock) begin
      spline_req_type it;
      if (!reset) begin
         if (!req_bus.valid || taken == issued) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (pend_q.size() > 0) begin
               it = pend_q.pop_front();
               req_bus.req_type    <= it.kind;
               req_bus.table_index <= it.idx;
               req_bus.table_value <= it.tval;
               req_bus.eval_point  <= it.xval;
               req_bus.valid       <= 1'b1;
               issued++;
               send_gap = pick_gap();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // response receiver ready, with random and one long hold-off
   int stall_left;
   always @(negedge clock) begin
      if (!reset) begin
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (hold_served < hold_asked) begin
            hold_served++;
            stall_left = HOLD_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            stall_left = pick_gap();
            rsp_bus.ready <= (stall_left == 0);
         end
      end
   end

   // accepted items feed the predictor, accepted results are checked
   always @(posedge clock) begin
      spline_req_type it;
      spline_rsp_type ex;
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("simulation failed");
         $finish;
      end else if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            it.kind = req_bus.req_type;
            it.idx  = req_bus.table_index;
            it.tval = req_bus.table_value;
            it.xval = req_bus.eval_point;
            expect_q.push_back(evaluate_item(it));
            taken++;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expect_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected response value %0d status %0d", $time,
                        rsp_bus.spline_value, rsp_bus.status);
            end else begin
               ex = expect_q.pop_front();
               n_checked++;
               n_status[rsp_bus.status]++;
               if (rsp_bus.spline_value !== ex.value) begin
                  errors++;
                  $display("%0t: spline_value expected %0d actual %0d", $time,
                           ex.value, rsp_bus.spline_value);
               end
               if (rsp_bus.status !== ex.status) begin
                  errors++;
                  $display("%0t: status expected %0d actual %0d", $time,
                           ex.status, rsp_bus.status);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // stimulus helpers
   task automatic push_item(logic [1:0] kind, int idx, logic signed [31:0] tv,
                            logic signed [31:0] xv);
      spline_req_type it;
      it.kind = kind;
      it.idx  = idx[TIDX_W-1:0];
      it.tval = tv;
      it.xval = xv;
      pend_q.push_back(it);
      n_items++;
      if (kind == REQ_EVAL)
         n_evals++;
   endtask

   task automatic wait_idle();
      while (pend_q.size() != 0 || req_bus.valid || expect_q.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int value);
      @(negedge clock);
      csr_bus.index <= idx;
      csr_bus.data  <= value[CSR_DATA_W-1:0];
      csr_bus.valid <= 1'b1;
      do @(posedge clock); while (!csr_bus.ready);
      if (idx == CSR_ENABLE)
         cfg_enable = value[0];
      else if (idx == CSR_DEGREE)
         cfg_degree = value & 7;
      else if (idx == CSR_COUNT)
         cfg_count = value & 8'h7f;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic configure(int en, int deg, int cnt);
      wait_idle();
      write_reg(CSR_ENABLE, en);
      write_reg(CSR_DEGREE, deg);
      write_reg(CSR_COUNT, cnt);
   endtask

   // knot and coefficient load, mostly sorted knots with some repeats
   task automatic load_tables(int cnt, bit wide);
      longint kv;
      int mode;
      mode = $urandom_range(0, 9);
      kv   = wide ? -longint'(32'h4000_0000) : longint'($signed($urandom_range(0, 32'h60000)))
             - 32'sh30000;
      for (int i = 0; i < cnt; i++) begin
         if (mode == 0)
            plan_knot[i] = longint'($signed($urandom()));
         else begin
            plan_knot[i] = kv;
            if ($urandom_range(0, 7) != 0)
               kv += wide ? $urandom_range(1, 32'h1F0_0000) : $urandom_range(1, 32'h40000);
         end
         push_item(REQ_KNOT, i, plan_knot[i][31:0], $urandom());
      end
      for (int i = 0; i < cnt; i++) begin
         case ($urandom_range(0, 9))
            0: push_item(REQ_COEF, i, 32'sh7fff_ffff, $urandom());
            1: push_item(REQ_COEF, i, 32'sh8000_0000, $urandom());
            2, 3: push_item(REQ_COEF, i, $urandom(), $urandom());
            default: push_item(REQ_COEF, i, $signed($urandom_range(0, 32'h200000)) - 32'sh100000,
                               $urandom());
         endcase
      end
   endtask

   // evaluation points, mostly inside the valid knot range
   function automatic logic signed [31:0] pick_point(int deg, int cnt);
      longint lo, hi;
      int p;
      p = $urandom_range(0, 9);
      if (p == 0 || deg < 1 || cnt - deg - 1 < 0 || cnt > MAX_KNOTS)
         return $urandom();
      lo = plan_knot[deg];
      hi = plan_knot[cnt - deg - 1];
      if (p == 1)
         return lo[31:0];
      if (p == 2)
         return hi[31:0];
      if (hi <= lo)
         return lo[31:0] + $signed($urandom_range(0, 64)) - 32;
      return 32'(lo + longint'($urandom_range(0, 32'hffff_ffff)) % (hi - lo + 1));
   endfunction

   task automatic run_phase(int en, int deg, int cnt, int evals, bit wide);
      bit reads;
      configure(en, deg, cnt);
      reads = en != 0 && deg >= 1 && deg < MAX_ORDER && cnt >= 2 * deg + 2 && cnt <= MAX_KNOTS;
      if (reads)
         load_tables(cnt, wide);
      for (int e = 0; e < evals; e++) begin
         case ($urandom_range(0, 19))
            0: push_item(REQ_SPARE, $urandom_range(0, 63), $urandom(), $urandom());
            1: push_item(REQ_COEF, reads ? $urandom_range(0, cnt - 1) : $urandom_range(0, 63),
                         $urandom(), $urandom());
            2: push_item(REQ_KNOT, $urandom_range(0, 63), $urandom(), $urandom());
            default: ;
         endcase
         push_item(REQ_EVAL, $urandom_range(0, 63), $urandom(), pick_point(deg, cnt));
      end
   endtask

   // ---------------------------------------------------------------
   initial begin
      int deg, cnt, kind;
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.req_type = REQ_KNOT;
      req_bus.table_index = '0;
      req_bus.table_value = '0;
      req_bus.eval_point = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_ENABLE;
      csr_bus.data = '0;
      cfg_enable = 1'b0;
      cfg_degree = 3;
      cfg_count = 8;
      errors = 0;
      steady = 0;
      foreach (knot_mem[i]) begin
         knot_mem[i] = 0;
         coef_mem[i] = 0;
      end
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: disabled with reset settings, unused kind, last index
      push_item(REQ_EVAL, 0, 0, 32'sh8000_0000);
      push_item(REQ_SPARE, 63, 32'sh7fff_ffff, 32'sh7fff_ffff);
      push_item(REQ_KNOT, 63, 32'sh7fff_ffff, 0);
      push_item(REQ_COEF, 63, 32'sh8000_0000, 0);
      // directed: extreme and invalid settings
      run_phase(1, 1, 4, 4, 0);
      run_phase(1, 5, 64, 4, 1);
      run_phase(1, 5, 12, 3, 0);
      run_phase(1, 0, 8, 1, 0);
      run_phase(1, 6, 14, 1, 0);
      run_phase(1, 7, 127, 1, 0);
      run_phase(1, 3, 7, 1, 0);
      run_phase(1, 2, 65, 1, 0);
      run_phase(0, 3, 8, 1, 0);
      push_item(REQ_EVAL, 0, 0, 32'sh7fff_ffff);

      // random phases
      for (int ph = 0; n_items < 600; ph++) begin
         steady = ($urandom_range(0, 4) == 0);
         kind = $urandom_range(0, 9);
         deg = $urandom_range(1, 5);
         cnt = 2 * deg + 2 + (($urandom_range(0, 7) == 0) ? $urandom_range(0, 64 - 2 * deg - 2)
                                                          : $urandom_range(0, 6));
         if (ph == 2) begin
            // long receiver hold-off while the sender keeps offering
            wait_idle();
            hold_asked++;
            run_phase(1, 1, 4, 12, 0);
         end else if (kind == 0)
            run_phase(0, deg, cnt, 3, 0);
         else if (kind == 1)
            run_phase(1, $urandom_range(0, 7), $urandom_range(0, 127), 3, 0);
         else
            run_phase(1, deg, cnt, $urandom_range(8, 25), $urandom_range(0, 5) == 0);
      end

      wait_idle();
      repeat (700) @(posedge clock);
      $display("%0d items, %0d evaluations, %0d responses checked", n_items, n_evals,
               n_checked);
      $display("status seen: ok %0d, disabled %0d, bad config %0d, zero span %0d",
               n_status[0], n_status[1], n_status[2], n_status[3]);
      if (errors == 0 && expect_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+hdl
hdl/bdb_pkg.sv
hdl/bdb_if.sv
hdl/bdb_ram.sv
hdl/bdb_datapath.sv
hdl/bdb_controller.sv
hdl/bspline_de_boor_eval_unit.sv
bench/tb.sv
